// ===== design/slc_pkg.sv =====
// Shared constants, types and command codes for the stride linear classifier.
`default_nettype none
package slc_pkg;

  // Block sizing
  localparam int NUM_CLASSES = 5;
  localparam int NUM_SIGNALS = 5;
  localparam int IN_CH       = 5;   // sample channels present on the input ports
  localparam int NUM_FEAT    = 2 * NUM_SIGNALS;
  localparam int NUM_WEIGHTS = NUM_CLASSES * NUM_FEAT;

  // Index widths
  localparam int WADDR_W = $clog2(NUM_WEIGHTS);
  localparam int CLS_W   = $clog2(NUM_CLASSES);
  localparam int FEAT_W  = $clog2(NUM_FEAT);
  localparam int SIG_W   = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;

  // Datapath widths
  localparam int CMD_W   = 2;
  localparam int CIDX_W  = 3;
  localparam int FIDX_W  = 4;
  localparam int SAMP_W  = 16;
  localparam int RANGE_W = SAMP_W + 1;
  localparam int WGT_W   = 16;
  localparam int BIAS_W  = 32;
  localparam int PROD_W  = WGT_W + RANGE_W;
  localparam int ACC_W   = 48;
  localparam int SCORE_W = 40;

  localparam logic signed [ACC_W-1:0] SCORE_MAX = 48'sh007F_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] SCORE_MIN = 48'shFF80_0000_0000;

  localparam logic signed [SAMP_W-1:0] SAMP_MOST_NEG = 16'sh8000;
  localparam logic signed [SAMP_W-1:0] SAMP_MOST_POS = 16'sh7FFF;

  // Transaction commands
  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_FOOT_OFF = 2'd1,
    CMD_WINDOW   = 2'd2,
    CMD_LOAD     = 2'd3
  } cmd_e;

  // Tag that travels alongside each multiply-accumulate step
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic [CLS_W-1:0] cls;
  } mac_tag_t;

endpackage
`default_nettype wire

// ===== design/stride_linear_classifier_top.sv =====
// Stride linear classifier top level: min/max tracking, weight store and scoring sequencer.
// Sample, foot-off and weight-load transactions produce no result.
// A window-close transaction yields its result after one weight-memory read and one
// multiply-accumulate step per weight, then drain.
// The input is stalled from window-close acceptance until the result enters the output register.
// Reset clears the tracked extrema, stride flag, weight valid bits (weights read as zero) and biases.
`default_nettype none
module stride_linear_classifier_top (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [slc_pkg::CMD_W-1:0]          cmd_i,
  input  wire logic signed [slc_pkg::SAMP_W-1:0]  rot_sample_i,
  input  wire logic signed [slc_pkg::SAMP_W-1:0]  omega_x_sample_i,
  input  wire logic signed [slc_pkg::SAMP_W-1:0]  accel_y_sample_i,
  input  wire logic signed [slc_pkg::SAMP_W-1:0]  accel_z_sample_i,
  input  wire logic signed [slc_pkg::SAMP_W-1:0]  angle_z_sample_i,
  input  wire logic [slc_pkg::CIDX_W-1:0]         class_index_i,
  input  wire logic [slc_pkg::FIDX_W-1:0]         feature_index_i,
  input  wire logic signed [slc_pkg::BIAS_W-1:0]  weight_value_i,
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic [slc_pkg::CIDX_W-1:0]             predicted_class_o,
  output logic signed [slc_pkg::SCORE_W-1:0]     best_score_o
);
  import slc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_WAIT
  } state_e;

  state_e                     state_q;
  logic                       in_acc;
  cmd_e                       cmd;

  logic signed [SAMP_W-1:0]   in_ch   [IN_CH];
  logic signed [SAMP_W-1:0]   samp    [NUM_SIGNALS];
  logic signed [SAMP_W-1:0]   max_q   [NUM_SIGNALS];
  logic signed [SAMP_W-1:0]   min_q   [NUM_SIGNALS];
  logic signed [SAMP_W-1:0]   fin_q   [NUM_SIGNALS];
  logic signed [BIAS_W-1:0]   bias_q  [NUM_CLASSES];
  logic                       done_q;

  logic signed [WGT_W-1:0]    wmem    [NUM_WEIGHTS];
  logic [NUM_WEIGHTS-1:0]     wvld_q;
  logic                       wr_en, bias_en;
  logic [WADDR_W-1:0]         wr_addr;
  logic [CLS_W-1:0]           wr_cls;

  logic [WADDR_W-1:0]         addr_q;
  logic [FEAT_W-1:0]          j_q;
  logic [CLS_W-1:0]           k_q;
  logic                       j_last, k_last;

  logic signed [WGT_W-1:0]    rd_q;
  logic                       rd_vld_q;
  logic signed [RANGE_W-1:0]  feat_d, feat_q;
  logic signed [BIAS_W-1:0]   bsel_q;
  mac_tag_t                   tag_d, tag_q, mac_tag;
  logic signed [WGT_W-1:0]    wgt;
  logic signed [ACC_W-1:0]    acc;

  logic signed [SCORE_W-1:0]  sat_q, best_q;
  logic                       sat_vld_q;
  logic [CLS_W-1:0]           sat_cls_q, best_cls_q;

  logic                       out_vld_q;
  logic [CIDX_W-1:0]          out_cls_q;
  logic signed [SCORE_W-1:0]  out_score_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cmd        = cmd_e'(cmd_i);

  // Channel fan-in; channels beyond the ports read as zero
  assign in_ch[0] = rot_sample_i;
  assign in_ch[1] = omega_x_sample_i;
  assign in_ch[2] = accel_y_sample_i;
  assign in_ch[3] = accel_z_sample_i;
  assign in_ch[4] = angle_z_sample_i;

  always_comb begin
    for (int s = 0; s < NUM_SIGNALS; s++) begin
      samp[s] = (s < IN_CH) ? in_ch[s % IN_CH] : '0;
    end
  end

  // Weight/bias load decode; out-of-range slots are dropped
  assign wr_cls  = CLS_W'(class_index_i);
  assign wr_en   = in_acc && (cmd == CMD_LOAD) && (32'(class_index_i) < NUM_CLASSES)
                   && (32'(feature_index_i) < NUM_FEAT);
  assign bias_en = in_acc && (cmd == CMD_LOAD) && (32'(class_index_i) < NUM_CLASSES)
                   && (32'(feature_index_i) == NUM_FEAT);
  assign wr_addr = WADDR_W'(32'(class_index_i) * NUM_FEAT + 32'(feature_index_i));

  // Weight memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wmem[wr_addr] <= weight_value_i[WGT_W-1:0];
    end
    rd_q <= wmem[addr_q];
  end

  // Feature select: range for the first half, final sample for the second
  always_comb begin
    if (32'(j_q) < NUM_SIGNALS) begin
      feat_d = RANGE_W'(max_q[SIG_W'(j_q)]) - RANGE_W'(min_q[SIG_W'(j_q)]);
    end else begin
      feat_d = RANGE_W'(fin_q[SIG_W'(j_q - FEAT_W'(NUM_SIGNALS))]);
    end
  end

  assign j_last = (j_q == FEAT_W'(NUM_FEAT - 1));
  assign k_last = (k_q == CLS_W'(NUM_CLASSES - 1));

  // Class run markers are only raised while issuing
  always_comb begin
    tag_d.vld   = (state_q == ST_RUN);
    tag_d.first = (state_q == ST_RUN) && (j_q == '0);
    tag_d.last  = (state_q == ST_RUN) && j_last;
    tag_d.cls   = k_q;
  end

  // Issue stage payload: feature and bias travel with the memory read
  always_ff @(posedge clk_i) begin
    feat_q <= feat_d;
    bsel_q <= bias_q[k_q];
  end

  assign wgt = rd_vld_q ? rd_q : '0;

  slc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag_q),
    .wgt_i  (wgt),
    .feat_i (feat_q),
    .bias_i (bsel_q),
    .acc_o  (acc),
    .tag_o  (mac_tag)
  );

  // Saturation stage
  always_ff @(posedge clk_i) begin
    if (acc > SCORE_MAX) begin
      sat_q <= SCORE_MAX[SCORE_W-1:0];
    end else if (acc < SCORE_MIN) begin
      sat_q <= SCORE_MIN[SCORE_W-1:0];
    end else begin
      sat_q <= acc[SCORE_W-1:0];
    end
    sat_cls_q <= mac_tag.cls;
  end

  // Sequencer, stride tracking, tables and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      done_q      <= 1'b0;
      wvld_q      <= '0;
      rd_vld_q    <= 1'b0;
      tag_q       <= '0;
      sat_vld_q   <= 1'b0;
      addr_q      <= '0;
      j_q         <= '0;
      k_q         <= '0;
      best_q      <= '0;
      best_cls_q  <= '0;
      out_vld_q   <= 1'b0;
      out_cls_q   <= '0;
      out_score_q <= '0;
      for (int s = 0; s < NUM_SIGNALS; s++) begin
        max_q[s] <= '0;
        min_q[s] <= '0;
        fin_q[s] <= '0;
      end
      for (int c = 0; c < NUM_CLASSES; c++) begin
        bias_q[c] <= '0;
      end
    end else begin
      rd_vld_q  <= wvld_q[addr_q];
      tag_q     <= tag_d;
      sat_vld_q <= mac_tag.vld && mac_tag.last;

      // Hand-off state reloads the output register itself
      if (out_vld_q && !out_stall_i && state_q != ST_WAIT) begin
        out_vld_q <= 1'b0;
      end

      if (wr_en) begin
        wvld_q[wr_addr] <= 1'b1;
      end
      if (bias_en) begin
        bias_q[wr_cls] <= weight_value_i;
      end

      // Running best: class 0 seeds it, later classes need a strictly higher score
      if (sat_vld_q && (sat_cls_q == '0 || sat_q > best_q)) begin
        best_q     <= sat_q;
        best_cls_q <= sat_cls_q;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (cmd)
              CMD_SAMPLE: begin
                if (!done_q) begin
                  for (int s = 0; s < NUM_SIGNALS; s++) begin
                    if (samp[s] > max_q[s]) max_q[s] <= samp[s];
                    if (samp[s] < min_q[s]) min_q[s] <= samp[s];
                  end
                end
              end
              CMD_FOOT_OFF: begin
                for (int s = 0; s < NUM_SIGNALS; s++) begin
                  max_q[s] <= SAMP_MOST_NEG;
                  min_q[s] <= SAMP_MOST_POS;
                end
                done_q <= 1'b0;
              end
              CMD_WINDOW: begin
                for (int s = 0; s < NUM_SIGNALS; s++) begin
                  fin_q[s] <= samp[s];
                end
                done_q  <= 1'b1;
                addr_q  <= '0;
                j_q     <= '0;
                k_q     <= '0;
                state_q <= ST_RUN;
              end
              CMD_LOAD: begin
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          addr_q <= addr_q + 1'b1;
          if (j_last) begin
            j_q <= '0;
            if (k_last) begin
              state_q <= ST_DRAIN;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (sat_vld_q && sat_cls_q == CLS_W'(NUM_CLASSES - 1)) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!out_vld_q || !out_stall_i) begin
            out_vld_q   <= 1'b1;
            out_cls_q   <= CIDX_W'(best_cls_q);
            out_score_q <= best_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_vld_q;
  assign predicted_class_o = out_cls_q;
  assign best_score_o      = out_score_q;

  // A new result only appears out of the hand-off state
  a_result_from_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_vld_q ##1 out_vld_q) |-> $past(state_q == ST_WAIT))
    else $error("result loaded outside hand-off state");
  a_score_only_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_vld_q |-> (state_q == ST_RUN || state_q == ST_DRAIN))
    else $error("class score produced while idle");
  a_issue_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (32'(addr_q) == 32'(k_q) * NUM_FEAT + 32'(j_q)))
    else $error("weight address out of step with class and feature counters");
  a_window_sets_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && $past(state_q) == ST_WAIT) |-> done_q)
    else $error("stride flag not set after classification");

endmodule
`default_nettype wire

// ===== design/slc_mac.sv =====
// Shared multiply-accumulate unit: registered multiply, then bias-seeded accumulate.
`default_nettype none
module slc_mac (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire slc_pkg::mac_tag_t                tag_i,
  input  wire logic signed [slc_pkg::WGT_W-1:0]   wgt_i,
  input  wire logic signed [slc_pkg::RANGE_W-1:0] feat_i,
  input  wire logic signed [slc_pkg::BIAS_W-1:0]  bias_i,
  output logic signed [slc_pkg::ACC_W-1:0]       acc_o,
  output slc_pkg::mac_tag_t                     tag_o
);
  import slc_pkg::*;

  mac_tag_t                   mul_tag_q, acc_tag_q;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [BIAS_W-1:0]   bias_q;
  logic signed [ACC_W-1:0]    acc_base, acc_d, acc_q;

  // Multiply stage
  assign prod_d = wgt_i * feat_i;

  // Accumulate stage: first term of a class starts from its bias
  assign acc_base = mul_tag_q.first ? ACC_W'(bias_q) : acc_q;
  assign acc_d    = acc_base + ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_tag_q <= '0;
      acc_tag_q <= '0;
    end else begin
      mul_tag_q <= tag_i;
      acc_tag_q <= mul_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    bias_q <= bias_i;
    if (mul_tag_q.vld) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;
  assign tag_o = acc_tag_q;

  // Tag checks: first only with valid, and valid, last and class pass the tag pipeline intact
  a_first_follows_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_tag_q.first |-> acc_tag_q.vld)
    else $error("accumulate stage first flag without valid");
  a_tag_pipeline : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_i.vld |=> ##1 acc_tag_q.vld)
    else $error("accumulate tag lost in the pipeline");
  a_last_class_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag_i.vld && tag_i.last) |=> ##1 (acc_tag_q.last && acc_tag_q.cls == $past(tag_i.cls, 2)))
    else $error("class tag corrupted in the pipeline");

endmodule
`default_nettype wire
